@@ design/dpf_pkg.sv @@
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared widths, register codes and item types for the derivative peak finder.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 20;
    localparam int THR_BITS    = 16;

    // compare width: holds -(-2^(S-1)) and -thr without overflow
    localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;

    localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((INDEX_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_THR   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_REBOUND_THR = CFG_IDX_BITS'(1);

    localparam logic [THR_BITS-1:0] START_THR_RESET   = THR_BITS'(1000);
    localparam logic [THR_BITS-1:0] REBOUND_THR_RESET = THR_BITS'(1500);

    typedef struct packed {
        logic                          last;
        logic                          invalid;
        logic signed [SAMPLE_BITS-1:0] level;
        logic signed [SAMPLE_BITS-1:0] slope;
    } t_sample;

    typedef struct packed {
        logic                  unterminated;
        logic [INDEX_BITS-1:0] peak_index;
    } t_result;

endpackage

@@ design/dpf_in_reg.sv @@
// ----------------------------------------------------------------------------
// dpf_in_reg
// Input register stage: captures one sample per transfer.
// ----------------------------------------------------------------------------
module dpf_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dpf_pkg::t_sample i_sample,
    input  logic             i_advance,   // core consumes the held sample
    output logic             o_valid,
    output dpf_pkg::t_sample o_sample
);

    logic             r_valid;
    dpf_pkg::t_sample r_sample;

    assign o_ready  = !r_valid || i_advance;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

endmodule

@@ design/dpf_core.sv @@
// ----------------------------------------------------------------------------
// dpf_core
// Threshold registers, channel state and the open/close decision for one
// sample. Result is combinational; the output stage registers it.
// ----------------------------------------------------------------------------
module dpf_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dpf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [dpf_pkg::THR_BITS-1:0]      i_cfg_data,
    input  logic                              i_fire,
    input  dpf_pkg::t_sample                  i_sample,
    output logic                              o_res_valid,
    output dpf_pkg::t_result                  o_result
);

    logic [dpf_pkg::THR_BITS-1:0]   r_start_thr;
    logic [dpf_pkg::THR_BITS-1:0]   r_rebound_thr;

    logic                           r_peak_open,  n_peak_open;
    logic                           r_pol_known,  n_pol_known;
    logic                           r_pol_neg,    n_pol_neg;
    logic                           r_thr_raised, n_thr_raised;
    logic [dpf_pkg::INDEX_BITS-1:0] r_open_index, n_open_index;
    logic [dpf_pkg::INDEX_BITS-1:0] r_count,      n_count;

    logic signed [dpf_pkg::CMP_BITS-1:0] thr_c;
    logic signed [dpf_pkg::CMP_BITS-1:0] slope_c;
    logic signed [dpf_pkg::CMP_BITS-1:0] mag_c;
    logic signed [dpf_pkg::CMP_BITS-1:0] pol_slope_c;
    logic                                pol_neg_eff;
    logic                                lvl_ok;
    logic                                slp_ok;
    logic [dpf_pkg::INDEX_BITS:0]        mid_sum;

    always_comb begin
        thr_c       = dpf_pkg::CMP_BITS'(r_thr_raised ? r_rebound_thr : r_start_thr);
        slope_c     = dpf_pkg::CMP_BITS'(i_sample.slope);
        mag_c       = (slope_c < 0) ? -slope_c : slope_c;
        pol_slope_c = r_pol_neg ? -slope_c : slope_c;
        pol_neg_eff = r_pol_known ? r_pol_neg : (slope_c < 0);
        lvl_ok      = pol_neg_eff ? (i_sample.level <= 0) : (i_sample.level >= 0);
        slp_ok      = pol_neg_eff ? (slope_c <= 0) : (slope_c >= 0);
        mid_sum     = {1'b0, r_open_index} + {1'b0, r_count};

        n_peak_open  = r_peak_open;
        n_pol_known  = r_pol_known;
        n_pol_neg    = r_pol_neg;
        n_thr_raised = r_thr_raised;
        n_open_index = r_open_index;
        n_count      = r_count;
        o_res_valid  = 1'b0;
        o_result     = '0;

        if (i_fire) begin
            if (i_sample.invalid) begin
                n_thr_raised = 1'b1;
            end else if (!r_peak_open && (mag_c > thr_c)) begin
                n_pol_known = 1'b1;
                n_pol_neg   = pol_neg_eff;
                if (lvl_ok && slp_ok) begin
                    n_peak_open  = 1'b1;
                    n_open_index = r_count;
                end
            end else if (r_peak_open && (pol_slope_c < -thr_c)) begin
                n_peak_open             = 1'b0;
                o_res_valid             = 1'b1;
                o_result.peak_index     = mid_sum[dpf_pkg::INDEX_BITS:1];
                o_result.unterminated   = 1'b0;
            end

            n_count = r_count + dpf_pkg::INDEX_BITS'(1);

            // end of record: report a still-open peak, then clear channel state
            if (i_sample.last) begin
                if (n_peak_open) begin
                    o_res_valid           = 1'b1;
                    o_result.peak_index   = n_open_index;
                    o_result.unterminated = 1'b1;
                end
                n_peak_open  = 1'b0;
                n_pol_known  = 1'b0;
                n_pol_neg    = 1'b0;
                n_thr_raised = 1'b0;
                n_open_index = '0;
                n_count      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr   <= dpf_pkg::START_THR_RESET;
            r_rebound_thr <= dpf_pkg::REBOUND_THR_RESET;
            r_peak_open   <= 1'b0;
            r_pol_known   <= 1'b0;
            r_pol_neg     <= 1'b0;
            r_thr_raised  <= 1'b0;
            r_open_index  <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dpf_pkg::REG_START_THR:   r_start_thr   <= i_cfg_data;
                    dpf_pkg::REG_REBOUND_THR: r_rebound_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            r_peak_open  <= n_peak_open;
            r_pol_known  <= n_pol_known;
            r_pol_neg    <= n_pol_neg;
            r_thr_raised <= n_thr_raised;
            r_open_index <= n_open_index;
            r_count      <= n_count;
        end
    end

endmodule

@@ design/dpf_out_reg.sv @@
// ----------------------------------------------------------------------------
// dpf_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module dpf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dpf_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,     // register can take a result this cycle
    output logic             o_valid,
    output dpf_pkg::t_result o_result
);

    logic             r_valid;
    dpf_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ design/derivative_peak_finder_top.sv @@
// ----------------------------------------------------------------------------
// derivative_peak_finder_top
// Threshold-based peak finder over a smoothed derivative stream, one channel.
//
//   channel  dir  handshake          payload
//   s_axis   in   tvalid/tready      tdata: slope, level; tuser: invalid; tlast
//   m_axis   out  tvalid/tready      tdata: peak_index; tuser: unterminated
//   cfg      in   i_cfg_we           i_cfg_index, i_cfg_data (no read-back)
//
// One sample per clock sustained while m_axis is not stalled. Path: input
// register, then the decision logic into the result register. Synchronous
// active-low reset clears the state and loads the default thresholds. A
// stalled result register holds the input stage, which in turn drops
// s_axis_tready.
// ----------------------------------------------------------------------------
module derivative_peak_finder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dpf_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // slope, level
    input  logic                                s_axis_tuser,  // invalid
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dpf_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // peak_index, zero pad
    output logic                                m_axis_tuser,  // unterminated
    input  logic                                i_cfg_we,
    input  logic [dpf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [dpf_pkg::THR_BITS-1:0]        i_cfg_data
);

    dpf_pkg::t_sample in_sample;
    dpf_pkg::t_sample held_sample;
    dpf_pkg::t_result core_result;
    dpf_pkg::t_result out_result;
    logic             held_valid;
    logic             out_free;
    logic             core_fire;
    logic             core_res_valid;

    always_comb begin
        in_sample.slope   = s_axis_tdata[dpf_pkg::SAMPLE_BITS-1:0];
        in_sample.level   = s_axis_tdata[2*dpf_pkg::SAMPLE_BITS-1:dpf_pkg::SAMPLE_BITS];
        in_sample.invalid = s_axis_tuser;
        in_sample.last    = s_axis_tlast;
    end

    assign core_fire = held_valid && out_free;

    dpf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (in_sample),
        .i_advance (core_fire),
        .o_valid   (held_valid),
        .o_sample  (held_sample)
    );

    dpf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (core_fire),
        .i_sample    (held_sample),
        .o_res_valid (core_res_valid),
        .o_result    (core_result)
    );

    dpf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_res_valid),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = dpf_pkg::OUT_TDATA_BITS'(out_result.peak_index);
    assign m_axis_tuser = out_result.unterminated;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for derivative_peak_finder_top. A clocked driver feeds
// sample transfers from a queue and tracks peak state for every accepted
// sample. A clocked monitor checks each result transfer against the oldest
// predicted peak. The initial block runs directed cases and then random
// channels under several threshold settings and idling mixes. It also runs a
// long receiver hold-off while the sender keeps offering samples.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpf_pkg::*;

    localparam int IDLE_LIMIT = 5000;   // cycles without any transfer
    localparam int RX_HOLD    = 300;    // long receiver hold-off
    localparam int PHASE_ITEMS = 440;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      s_axis_tuser  = 1'b0;
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [THR_BITS-1:0]       i_cfg_data  = '0;

    derivative_peak_finder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of thresholds and detector state
    logic [THR_BITS-1:0]   start_thr   = START_THR_RESET;
    logic [THR_BITS-1:0]   rebound_thr = REBOUND_THR_RESET;
    bit                    pk_open, pol_known, pol_neg, thr_raised;
    logic [INDEX_BITS-1:0] open_idx, sample_idx;

    t_sample sample_q[$];
    t_result peak_q[$];
    t_sample cur_sample;

    int unsigned sender_idle_pct = 0;
    int unsigned rx_stall_pct    = 0;
    int unsigned hold_rx_seq     = 0;
    int unsigned hold_rx_seen    = 0;
    int unsigned rx_hold_left    = 0;
    int unsigned idle_cycles     = 0;
    int unsigned n_samples       = 0;
    int unsigned n_peaks         = 0;
    int unsigned n_open_ended    = 0;
    int unsigned n_fail          = 0;

    function automatic void clear_detector();
        pk_open    = 1'b0;
        pol_known  = 1'b0;
        pol_neg    = 1'b0;
        thr_raised = 1'b0;
        open_idx   = '0;
        sample_idx = '0;
    endfunction

    // advance the detector by one accepted sample, queue any peak it yields
    function automatic void detect_peak(input t_sample smp);
        int                  slope_v, level_v, mag, thr, signed_slope;
        bit                  lvl_ok, slp_ok, have_res;
        logic [INDEX_BITS:0] span;
        t_result             res;
        slope_v  = $signed(smp.slope);
        level_v  = $signed(smp.level);
        have_res = 1'b0;
        res      = '0;
        if (smp.invalid) begin
            thr_raised = 1'b1;
        end else begin
            thr = thr_raised ? int'(rebound_thr) : int'(start_thr);
            mag = (slope_v < 0) ? -slope_v : slope_v;
            if (!pk_open && mag > thr) begin
                if (!pol_known) begin
                    pol_known = 1'b1;
                    pol_neg   = (slope_v < 0);
                end
                lvl_ok = pol_neg ? (level_v <= 0) : (level_v >= 0);
                slp_ok = pol_neg ? (slope_v <= 0) : (slope_v >= 0);
                if (lvl_ok && slp_ok) begin
                    pk_open  = 1'b1;
                    open_idx = sample_idx;
                end
            end else if (pk_open) begin
                signed_slope = pol_neg ? -slope_v : slope_v;
                if (signed_slope < -thr) begin
                    pk_open          = 1'b0;
                    span             = {1'b0, open_idx} + {1'b0, sample_idx};
                    res.peak_index   = span[INDEX_BITS:1];
                    res.unterminated = 1'b0;
                    have_res         = 1'b1;
                end
            end
        end
        sample_idx = sample_idx + INDEX_BITS'(1);
        if (smp.last) begin
            if (pk_open) begin
                res.peak_index   = open_idx;
                res.unterminated = 1'b1;
                have_res         = 1'b1;
            end
            clear_detector();
        end
        if (have_res)
            peak_q = {peak_q, res};
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                detect_peak(cur_sample);
                n_samples++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cur_sample = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_sample.level, cur_sample.slope};
                    s_axis_tuser  <= cur_sample.invalid;
                    s_axis_tlast  <= cur_sample.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (peak_q.size() == 0) begin
                    $error("unexpected result: peak_index %0d, unterminated %0b",
                           m_axis_tdata[INDEX_BITS-1:0], m_axis_tuser);
                    n_fail++;
                end else begin
                    exp_res = peak_q.pop_front();
                    n_peaks++;
                    if (exp_res.unterminated)
                        n_open_ended++;
                    if (m_axis_tdata[INDEX_BITS-1:0] !== exp_res.peak_index) begin
                        $error("peak_index: expected %0d, got %0d",
                               exp_res.peak_index, m_axis_tdata[INDEX_BITS-1:0]);
                        n_fail++;
                    end
                    if (m_axis_tuser !== exp_res.unterminated) begin
                        $error("unterminated: expected %0b, got %0b",
                               exp_res.unterminated, m_axis_tuser);
                        n_fail++;
                    end
                    if (m_axis_tdata[OUT_TDATA_BITS-1:INDEX_BITS] !== '0) begin
                        $error("tdata pad: expected 0, got %0h",
                               m_axis_tdata[OUT_TDATA_BITS-1:INDEX_BITS]);
                        n_fail++;
                    end
                end
            end
            if (hold_rx_seq != hold_rx_seen) begin
                hold_rx_seen  <= hold_rx_seq;
                rx_hold_left  <= RX_HOLD;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_left != 0) begin
                rx_hold_left  <= rx_hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[derivative_peak_finder_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_sample(input int slope_v, input int level_v,
                               input bit invalid, input bit last);
        t_sample smp;
        smp.slope   = SAMPLE_BITS'(slope_v);
        smp.level   = SAMPLE_BITS'(level_v);
        smp.invalid = invalid;
        smp.last    = last;
        sample_q = {sample_q, smp};
    endtask

    // one channel record: mostly pulses of the channel's polarity and
    // closing slopes, some quiet samples, invalid marks and pure noise
    task automatic push_channel(input int len);
        bit      neg, raised;
        int      thr, mag, kind, sgn, lvl;
        t_sample smp;
        neg    = 1'($urandom_range(0, 1));
        raised = 1'b0;
        for (int i = 0; i < len; i++) begin
            thr  = raised ? int'(rebound_thr) : int'(start_thr);
            kind = $urandom_range(0, 99);
            smp  = '0;
            if (kind < 4) begin
                smp.invalid = 1'b1;
                smp.slope   = SAMPLE_BITS'($urandom);
                smp.level   = SAMPLE_BITS'($urandom);
                raised      = 1'b1;
            end else if (kind < 12) begin
                smp.slope = SAMPLE_BITS'($urandom);
                smp.level = SAMPLE_BITS'($urandom);
            end else if (kind < 62) begin
                sgn = ((kind < 40) ^ neg) ? 1 : -1;
                mag = (thr >= 32768) ? $urandom_range(0, 32768) : $urandom_range(thr + 1, 32768);
                if (sgn > 0 && mag == 32768)
                    mag = 32767;
                lvl = $urandom_range(0, 32767);
                if (kind < 40)
                    smp.level = SAMPLE_BITS'(neg ? -lvl : lvl);
                else
                    smp.level = SAMPLE_BITS'($urandom);
                smp.slope = SAMPLE_BITS'(sgn * mag);
            end else begin
                mag = $urandom_range(0, (thr > 32767) ? 32767 : thr);
                smp.slope = SAMPLE_BITS'($urandom_range(0, 1) ? -mag : mag);
                smp.level = SAMPLE_BITS'($urandom);
            end
            smp.last = (i == len - 1);
            sample_q = {sample_q, smp};
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [THR_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_START_THR)
            start_thr = val;
        else if (idx == REG_REBOUND_THR)
            rebound_thr = val;
        @(negedge i_clk);
    endtask

    // all sent, all results back, then a wait for samples still in flight
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || peak_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int unsigned phase_idle[4]  = '{0, 52, 0, 11};
        int unsigned phase_stall[4] = '{0, 0, 52, 11};
        int pushed, len;

        clear_detector();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset thresholds 1000 / 1500
        push_sample(2000, 100, 0, 0);       // sets positive polarity, opens
        push_sample(0, 0, 0, 0);
        push_sample(-2000, 5, 0, 0);        // closes
        push_sample(-2000, -5, 0, 0);       // wrong slope sign, skipped
        push_sample(1001, 0, 0, 0);         // zero level opens
        push_sample(-1000, 0, 0, 0);        // exactly at threshold, stays open
        push_sample(-32768, 0, 1, 0);       // invalid, threshold raised
        push_sample(-1501, 0, 0, 0);        // closes on raised threshold
        push_sample(1500, 5, 0, 0);         // not above raised threshold
        push_sample(32767, 32767, 0, 0);    // opens
        push_sample(0, -32768, 0, 1);       // record ends while open
        push_sample(-32768, -32768, 0, 0);  // negative polarity, opens
        push_sample(1001, 0, 0, 0);         // closes
        push_sample(-2000, 3, 0, 0);        // level of wrong sign
        push_sample(5000, -1, 0, 0);        // slope of wrong sign
        push_sample(-2000, 0, 0, 0);        // opens
        push_sample(0, 0, 1, 1);            // invalid last sample, open ended
        push_sample(3000, -10, 0, 0);       // polarity fixed, no opening
        push_sample(-3000, -10, 0, 0);      // polarity stays positive
        push_sample(3000, 10, 0, 0);        // opens
        push_sample(-3000, 0, 0, 1);        // closes on the last sample
        push_sample(32767, 0, 0, 1);        // one-sample record, open ended
        wait_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    cfg_write(REG_START_THR, '0);
                    cfg_write(REG_REBOUND_THR, '1);
                end
                1: begin
                    cfg_write(REG_START_THR, THR_BITS'($urandom_range(0, 12000)));
                    cfg_write(REG_REBOUND_THR, THR_BITS'($urandom_range(0, 20000)));
                end
                2: begin
                    cfg_write(REG_START_THR, '1);
                    cfg_write(REG_REBOUND_THR, '0);
                end
                default: begin
                    cfg_write(REG_START_THR, THR_BITS'($urandom_range(0, 30000)));
                    cfg_write(REG_REBOUND_THR, THR_BITS'($urandom_range(0, 65535)));
                end
            endcase
            sender_idle_pct = phase_idle[ph];
            rx_stall_pct    = phase_stall[ph];
            pushed = 0;
            while (pushed < PHASE_ITEMS) begin
                len = $urandom_range(1, 40);
                push_channel(len);
                pushed += len;
            end
            wait_quiet();
        end

        // receiver holds off while back-to-back pulses keep coming
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        cfg_write(REG_START_THR, START_THR_RESET);
        cfg_write(REG_REBOUND_THR, REBOUND_THR_RESET);
        hold_rx_seq++;
        for (int i = 0; i < 40; i++) begin
            push_sample(20000, 100 + i, 0, 0);
            push_sample(-20000, 0, 0, i == 39);
        end
        wait_quiet();

        $display("%0d samples sent, %0d peaks checked (%0d open at end of record)",
                 n_samples, n_peaks, n_open_ended);
        $display("thresholds 0..65535, idling and stalls on both sides, long hold-off");
        if (n_fail == 0)
            $display("[derivative_peak_finder_top] OK");
        else
            $display("[derivative_peak_finder_top] ERROR");
        $finish;
    end

endmodule
